// ===== rtl/core/dlp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dlp_pkg;

   localparam int TAG_W    = 8;
   localparam int LEN_W    = 8;
   localparam int START_W  = 12;
   localparam int INDEX_W  = 6;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_TRUNC = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MANY  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_LONG  = 2'd3;

   localparam logic KIND_DESCRIPTOR = 1'b0;
   localparam logic KIND_SUMMARY    = 1'b1;

   typedef struct packed {
      logic                record_kind;
      logic [TAG_W-1:0]    tag;
      logic [LEN_W-1:0]    body_length;
      logic [START_W-1:0]  start_offset;
      logic [INDEX_W-1:0]  index;
      logic [WORD_W-1:0]   first_word;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
      logic                last;
   } rec_type;

endpackage

`default_nettype wire

// ===== rtl/core/descriptor_loop_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Descriptor loop parser.
// The req_ channel carries one byte of a transport-stream descriptor loop per
// transaction, with req_end_of_loop on the final one; req_carries_byte low with
// req_end_of_loop high closes a loop without a byte.
// The rsp_ channel returns a record for each completed descriptor (tag, length,
// start offset, index, first four body bytes) and a summary record (count,
// status) at loop end; rsp_last marks the final record caused by one request.
// Each byte is parsed in the cycle it is accepted and its records are written
// into a four-entry output queue of registers whose head drives the rsp_ outputs.
// One request is taken every cycle while the queue has room for
// two records; a stalled receiver fills the queue and then drops req_ready.
// Throughput is one byte per cycle as long as the receiver takes one record
// per cycle; the output queue's single read port bounds the record rate.
// Synchronous reset clears the parser to the start of a loop and empties the
// queue.
module descriptor_loop_parser #(
   parameter int MAX_DESCRIPTORS = 64,
   parameter int MAX_LOOP_BYTES  = 4096
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_carries_byte,
   input  wire logic [7:0]                    req_byte_value,
   input  wire logic                          req_end_of_loop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_record_kind,
   output logic [dlp_pkg::TAG_W-1:0]          rsp_tag,
   output logic [dlp_pkg::LEN_W-1:0]          rsp_body_length,
   output logic [dlp_pkg::START_W-1:0]        rsp_start_offset,
   output logic [dlp_pkg::INDEX_W-1:0]        rsp_index,
   output logic [dlp_pkg::WORD_W-1:0]         rsp_first_word,
   output logic [dlp_pkg::STATUS_W-1:0]       rsp_status,
   output logic [dlp_pkg::COUNT_W-1:0]        rsp_count,
   output logic                               rsp_last
);
   import dlp_pkg::*;

   localparam int OFS_W = $clog2(MAX_LOOP_BYTES + 1);
   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   typedef enum logic [1:0] {
      PH_TAG,
      PH_LEN,
      PH_BODY
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic [TAG_W-1:0]    tag_ff, tag_in;
   logic [LEN_W-1:0]    length_ff, length_in;
   logic [7:0]          seen_ff, seen_in;
   logic [OFS_W-1:0]    offset_ff, offset_in;
   logic [START_W-1:0]  start_ff, start_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [WORD_W-1:0]   word_ff, word_in;
   logic [STATUS_W-1:0] error_ff, error_in;

   rec_type             queue_ff [QDEPTH];
   logic [QPTR_W-1:0]   head_ff;
   logic [QCNT_W-1:0]   fill_ff;

   logic                accept;
   logic                pop;
   logic                desc_done;
   logic [1:0]          n_push;
   rec_type             desc_rec, sum_rec, first_rec;
   logic [STATUS_W-1:0] sum_status;
   logic [QPTR_W-1:0]   tail;
   logic [WORD_W-1:0]   word_start;
   logic [7:0]          seen_next;

   assign accept    = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = (fill_ff <= QCNT_W'(QDEPTH - 2));
   assign rsp_valid = (fill_ff != '0);

   // Byte parsing: one step of the tag/length/body walk per accepted byte.
   always_comb begin
      phase_in   = phase_ff;
      tag_in     = tag_ff;
      length_in  = length_ff;
      seen_in    = seen_ff;
      offset_in  = offset_ff;
      start_in   = start_ff;
      count_in   = count_ff;
      word_in    = word_ff;
      error_in   = error_ff;
      desc_done  = 1'b0;
      word_start = word_ff;
      seen_next  = seen_ff + 8'd1;

      if (req_carries_byte && error_ff == ST_OK) begin
         if (offset_ff >= OFS_W'(MAX_LOOP_BYTES)) begin
            error_in = ST_LONG;
         end else begin
            offset_in = offset_ff + OFS_W'(1);
            unique case (phase_ff)
               PH_TAG: begin
                  if (count_ff >= COUNT_W'(MAX_DESCRIPTORS)) begin
                     error_in  = ST_MANY;
                     offset_in = offset_ff;
                  end else begin
                     tag_in   = req_byte_value;
                     start_in = START_W'(offset_ff);
                     phase_in = PH_LEN;
                  end
               end
               PH_LEN: begin
                  length_in = req_byte_value;
                  seen_in   = '0;
                  word_in   = '0;
                  if (req_byte_value == 8'd0) begin
                     desc_done = 1'b1;
                     phase_in  = PH_TAG;
                  end else begin
                     phase_in = PH_BODY;
                  end
               end
               default: begin
                  if (seen_ff < 8'd4) begin
                     unique case (seen_ff[1:0])
                        2'd0:    word_start[31:24] = req_byte_value;
                        2'd1:    word_start[23:16] = req_byte_value;
                        2'd2:    word_start[15:8]  = req_byte_value;
                        default: word_start[7:0]   = req_byte_value;
                     endcase
                  end
                  word_in = word_start;
                  seen_in = seen_next;
                  if (seen_next == length_ff) begin
                     desc_done = 1'b1;
                     phase_in  = PH_TAG;
                  end
               end
            endcase
         end
      end

      if (desc_done) begin
         count_in = count_ff + COUNT_W'(1);
      end
   end

   // Record formation from the values after this byte.
   always_comb begin
      desc_rec              = '0;
      desc_rec.record_kind  = KIND_DESCRIPTOR;
      desc_rec.tag          = tag_in;
      desc_rec.body_length  = length_in;
      desc_rec.start_offset = start_in;
      desc_rec.index        = count_ff[INDEX_W-1:0];
      desc_rec.first_word   = word_in;
      desc_rec.last         = !req_end_of_loop;

      sum_status = error_in;
      if (error_in == ST_OK && phase_in != PH_TAG) begin
         sum_status = ST_TRUNC;
      end
      sum_rec             = '0;
      sum_rec.record_kind = KIND_SUMMARY;
      sum_rec.status      = sum_status;
      sum_rec.count       = count_in;
      sum_rec.last        = 1'b1;

      first_rec = desc_done ? desc_rec : sum_rec;
      n_push    = 2'(desc_done) + 2'(req_end_of_loop);
      tail      = head_ff + fill_ff[QPTR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TAG;
         tag_ff    <= '0;
         length_ff <= '0;
         seen_ff   <= '0;
         offset_ff <= '0;
         start_ff  <= '0;
         count_ff  <= '0;
         word_ff   <= '0;
         error_ff  <= ST_OK;
         head_ff   <= '0;
         fill_ff   <= '0;
      end else begin
         if (accept) begin
            if (req_end_of_loop) begin
               // The loop is closed: start the next one from a clean state.
               phase_ff  <= PH_TAG;
               tag_ff    <= '0;
               length_ff <= '0;
               seen_ff   <= '0;
               offset_ff <= '0;
               start_ff  <= '0;
               count_ff  <= '0;
               word_ff   <= '0;
               error_ff  <= ST_OK;
            end else begin
               phase_ff  <= phase_in;
               tag_ff    <= tag_in;
               length_ff <= length_in;
               seen_ff   <= seen_in;
               offset_ff <= offset_in;
               start_ff  <= start_in;
               count_ff  <= count_in;
               word_ff   <= word_in;
               error_ff  <= error_in;
            end
         end
         if (pop) begin
            head_ff <= head_ff + QPTR_W'(1);
         end
         fill_ff <= fill_ff + (accept ? QCNT_W'(n_push) : '0) - QCNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (accept && n_push != 2'd0) begin
         queue_ff[tail] <= first_rec;
      end
      if (accept && n_push == 2'd2) begin
         queue_ff[tail + QPTR_W'(1)] <= sum_rec;
      end
   end

   assign rsp_record_kind  = queue_ff[head_ff].record_kind;
   assign rsp_tag          = queue_ff[head_ff].tag;
   assign rsp_body_length  = queue_ff[head_ff].body_length;
   assign rsp_start_offset = queue_ff[head_ff].start_offset;
   assign rsp_index        = queue_ff[head_ff].index;
   assign rsp_first_word   = queue_ff[head_ff].first_word;
   assign rsp_status       = queue_ff[head_ff].status;
   assign rsp_count        = queue_ff[head_ff].count;
   assign rsp_last         = queue_ff[head_ff].last;

endmodule

`default_nettype wire
